/* hw/rtl/sfw_pkg.sv */
// ----------------------------------------------------------------------------
// sfw_pkg
// Shared constants and types for the sync/count/footer word receiver.
// ----------------------------------------------------------------------------
package sfw_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned PART_W  = 24;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'd5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'd205;
	localparam logic [BYTE_W-1:0] FOOTER_GOOD = 8'd128;
	localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd32;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_COUNT   = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_FOOTER  = 2'd3;

	localparam logic [1:0] KIND_WORD       = 2'd0;
	localparam logic [1:0] KIND_GOOD       = 2'd1;
	localparam logic [1:0] KIND_BAD_FOOTER = 2'd2;
	localparam logic [1:0] KIND_OVER_LIMIT = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] value;
		logic [BYTE_W-1:0] index;
		logic [BYTE_W-1:0] words;
	} res_t;

endpackage

/* hw/rtl/sfw_core.sv */
// ----------------------------------------------------------------------------
// sfw_core
// Frame parser: sync hunt, count check, little-endian word assembly, footer.
// ----------------------------------------------------------------------------
module sfw_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [sfw_pkg::BYTE_W-1:0] in_byte,
	input  logic [sfw_pkg::BYTE_W-1:0] word_limit,
	output logic                      res_valid,
	output sfw_pkg::res_t             res
);
	import sfw_pkg::*;

	logic [1:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] prev_q, prev_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [PART_W-1:0] part_q, part_d;
	logic [POS_W-1:0]  total;
	logic              hit;

	assign total = {count_q, 2'b00};

	always_comb begin
		phase_d = phase_q;
		prev_d  = prev_q;
		count_d = count_q;
		pos_d   = pos_q;
		part_d  = part_q;
		hit     = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (prev_q == SYNC_FIRST && in_byte == SYNC_SECOND) begin
					phase_d = PH_COUNT;
				end else begin
					prev_d = in_byte;
				end
			end
			PH_COUNT: begin
				count_d = in_byte;
				if (in_byte > word_limit) begin
					hit       = 1'b1;
					res.kind  = KIND_OVER_LIMIT;
					res.words = in_byte;
					phase_d   = PH_HUNT;
					prev_d    = '0;
				end else begin
					pos_d   = '0;
					part_d  = '0;
					phase_d = (in_byte == '0) ? PH_FOOTER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				case (pos_q[1:0])
					2'd0: part_d = {16'h0000, in_byte};
					2'd1: part_d = part_q | {8'h00, in_byte, 8'h00};
					2'd2: part_d = part_q | {in_byte, 16'h0000};
					default: begin
						hit       = 1'b1;
						res.kind  = KIND_WORD;
						res.value = {in_byte, part_q};
						res.index = pos_q[POS_W-1:2];
						res.words = count_q;
					end
				endcase
				pos_d = pos_q + 1'b1;
				if (pos_d >= total) begin
					phase_d = PH_FOOTER;
				end
			end
			PH_FOOTER: begin
				hit       = 1'b1;
				res.kind  = (in_byte == FOOTER_GOOD) ? KIND_GOOD : KIND_BAD_FOOTER;
				res.words = count_q;
				phase_d   = PH_HUNT;
				prev_d    = '0;
			end
		endcase
	end

	assign res_valid = in_valid & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prev_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			part_q  <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			part_q  <= part_d;
		end
	end

endmodule

/* hw/rtl/sync_frame_word_receiver.sv */
// ----------------------------------------------------------------------------
// sync_frame_word_receiver
// Deframes a byte stream into 32-bit payload words and frame status results.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while s_tready is high; the frame state updates in the
// accept cycle and any result goes into the two-entry output (register plus skid),
// which lets input keep flowing while a result waits, so the sustained rate is one
// byte per clock until the skid fills. word_limit is sampled at the count byte.
module sync_frame_word_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // word_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,     // [31:0] word_value, [39:32] word_index, [47:40] frame_words
	output logic [1:0]  m_tuser      // [1:0] result_kind
);
	import sfw_pkg::*;

	logic [BYTE_W-1:0] limit_q;
	logic              acc;
	logic              res_valid;
	res_t              res;
	logic              out_valid_s1;
	res_t              out_s1;
	logic              skid_valid_q;
	res_t              skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign s_tready = ~skid_valid_q;
	assign acc      = s_tvalid & s_tready;

	sfw_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (acc),
		.in_byte    (s_tdata),
		.word_limit (limit_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_s1 || m_tready) begin
			if (skid_valid_q) begin
				out_valid_s1 <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_s1 <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_s1 || m_tready) begin
			out_s1 <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tdata  = {out_s1.words, out_s1.index, out_s1.value};
	assign m_tuser  = out_s1.kind;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_s1)
		else $error("skid entry held with empty output register");

	a_word_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && out_s1.kind == KIND_WORD) |-> (out_s1.index < out_s1.words))
		else $error("payload word index beyond announced count");

	a_status_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && out_s1.kind != KIND_WORD) |-> (out_s1.value == '0 && out_s1.index == '0))
		else $error("status result with nonzero word fields");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && !m_tready && res_valid) |=> skid_valid_q)
		else $error("result dropped while output stalled");
`endif

endmodule
